// ===== hdl/bandwidth_ewma_estimator_macros.svh =====
// Assertion helpers for the bandwidth estimator checker.
// Both sample on the rising edge of i_clk and are off while i_rst_n is low.
`ifndef BANDWIDTH_EWMA_ESTIMATOR_MACROS_SVH
`define BANDWIDTH_EWMA_ESTIMATOR_MACROS_SVH

// Same-cycle implication.
`define BWE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bwe check failed");

// Next-cycle implication.
`define BWE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bwe check failed");

`endif

// ===== hdl/bwe_pkg.sv =====
package bwe_pkg;

    localparam int W_DATA  = 48;
    localparam int W_MS    = 32;
    localparam int W_CHUNK = 16;
    localparam int W_DIVD  = 58;   // x * 1000 for a 48-bit x
    localparam int W_PC    = 5;
    localparam int W_IDX   = 2;

    localparam logic [W_CHUNK-1:0] MIN_CHUNK_RST = 16'd1024;

    // register index map
    localparam logic [W_IDX-1:0] REG_MIN_CHUNK   = 2'd0;
    localparam logic [W_IDX-1:0] REG_RANGE_BEGIN = 2'd1;
    localparam logic [W_IDX-1:0] REG_RANGE_END   = 2'd2;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_DIFF,
        OP_RATE_GO,
        OP_RATE_SAT,
        OP_BLEND_GO,
        OP_BLEND_DONE,
        OP_SEED,
        OP_SETBASE,
        OP_LEFT,
        OP_REM_GO,
        OP_REM_DONE,
        OP_UNKNOWN,
        OP_EMIT
    } t_op;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_REQ,
        C_BASE_ZERO,
        C_SKIP,
        C_DIV_BUSY,
        C_BW_ZERO,
        C_OUT_FULL
    } t_cond;

    typedef struct packed {
        t_op              op;
        t_cond            cond;
        logic [W_PC-1:0]  target;
    } t_uop;

    typedef struct packed {
        logic no_req;
        logic base_zero;
        logic skip;
        logic div_busy;
        logic bw_zero;
        logic out_full;
    } t_flags;

    // program entry points
    localparam logic [W_PC-1:0] PC_IDLE      = 5'd0;
    localparam logic [W_PC-1:0] PC_RATE_WAIT = 5'd5;
    localparam logic [W_PC-1:0] PC_BLND_WAIT = 5'd8;
    localparam logic [W_PC-1:0] PC_SEED      = 5'd10;
    localparam logic [W_PC-1:0] PC_SETBASE   = 5'd11;
    localparam logic [W_PC-1:0] PC_REMAIN    = 5'd12;
    localparam logic [W_PC-1:0] PC_REM_WAIT  = 5'd14;
    localparam logic [W_PC-1:0] PC_UNKNOWN   = 5'd16;
    localparam logic [W_PC-1:0] PC_EMIT      = 5'd17;

    function automatic t_uop uw(input t_op op, input t_cond cond,
                                input logic [W_PC-1:0] target);
        t_uop u;
        u.op     = op;
        u.cond   = cond;
        u.target = target;
        return u;
    endfunction

    // Microprogram: branch to target when cond holds, else fall through.
    function automatic t_uop prog_word(input logic [W_PC-1:0] pc);
        t_uop u;
        unique case (pc)
            5'd0:    u = uw(OP_ACCEPT,     C_NO_REQ,    PC_IDLE);
            5'd1:    u = uw(OP_NOP,        C_BASE_ZERO, PC_SETBASE);
            5'd2:    u = uw(OP_DIFF,       C_NEVER,     PC_IDLE);
            5'd3:    u = uw(OP_NOP,        C_SKIP,      PC_REMAIN);
            5'd4:    u = uw(OP_RATE_GO,    C_NEVER,     PC_IDLE);
            5'd5:    u = uw(OP_NOP,        C_DIV_BUSY,  PC_RATE_WAIT);
            5'd6:    u = uw(OP_RATE_SAT,   C_BW_ZERO,   PC_SEED);
            5'd7:    u = uw(OP_BLEND_GO,   C_NEVER,     PC_IDLE);
            5'd8:    u = uw(OP_NOP,        C_DIV_BUSY,  PC_BLND_WAIT);
            5'd9:    u = uw(OP_BLEND_DONE, C_ALWAYS,    PC_REMAIN);
            5'd10:   u = uw(OP_SEED,       C_ALWAYS,    PC_REMAIN);
            5'd11:   u = uw(OP_SETBASE,    C_NEVER,     PC_IDLE);
            5'd12:   u = uw(OP_LEFT,       C_BW_ZERO,   PC_UNKNOWN);
            5'd13:   u = uw(OP_REM_GO,     C_NEVER,     PC_IDLE);
            5'd14:   u = uw(OP_NOP,        C_DIV_BUSY,  PC_REM_WAIT);
            5'd15:   u = uw(OP_REM_DONE,   C_ALWAYS,    PC_EMIT);
            5'd16:   u = uw(OP_UNKNOWN,    C_NEVER,     PC_IDLE);
            5'd17:   u = uw(OP_EMIT,       C_OUT_FULL,  PC_EMIT);
            default: u = uw(OP_NOP,        C_ALWAYS,    PC_IDLE);
        endcase
        return u;
    endfunction

endpackage

// ===== hdl/bandwidth_ewma_estimator.sv =====
// Channel   Dir  Handshake                 Payload
// in        in   i_in_valid / o_in_stall   i_now_ms[47:0], i_bytes_total[47:0]
// out       out  o_out_valid / i_out_stall o_bw_estimate[47:0], o_remaining_ms[31:0]
// cfg       in   i_cfg_we                  i_cfg_idx[1:0], i_cfg_data[47:0]
//
// One request at a time; the shared divider does the 1-bit restoring divisions
// (rate, remaining time) and the digit-wise /10 of a blend.
// Each request also waits at its emit while a stalled result fills the output.
// Reset is synchronous, active low: clears the estimator, loads min_chunk = 1024.
// A stalled result holds in the output register while the next request is taken.
module bandwidth_ewma_estimator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        i_cfg_we,
    input  logic [bwe_pkg::W_IDX-1:0]   i_cfg_idx,
    input  logic [bwe_pkg::W_DATA-1:0]  i_cfg_data,
    // receive events
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [bwe_pkg::W_DATA-1:0]  i_now_ms,
    input  logic [bwe_pkg::W_DATA-1:0]  i_bytes_total,
    // estimates
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [bwe_pkg::W_DATA-1:0]  o_bw_estimate,
    output logic [bwe_pkg::W_MS-1:0]    o_remaining_ms
);

    // Microcode word from the sequencer drives the datapath; the datapath
    // hands back the branch conditions.
    bwe_pkg::t_uop   uop;
    bwe_pkg::t_flags flags;

    bwe_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_uop   (uop)
    );

    // Datapath: base point, estimate, config registers, the shared divider
    // and the output register.
    bwe_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_uop          (uop),
        .o_flags        (flags),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_now_ms       (i_now_ms),
        .i_bytes_total  (i_bytes_total),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_bw_estimate  (o_bw_estimate),
        .o_remaining_ms (o_remaining_ms)
    );

endmodule

// ===== hdl/bwe_div.sv =====
module bwe_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_dec,
    input  logic [bwe_pkg::W_DIVD-1:0]    i_dividend,
    input  logic [bwe_pkg::W_DATA-1:0]    i_divisor,
    output logic                          o_busy,
    output logic [bwe_pkg::W_DIVD-1:0]    o_quot
);

    localparam int W_CNT = 6;
    localparam logic [W_CNT-1:0] BIN_STEPS = 6'd58;   // one bit per cycle
    localparam logic [W_CNT-1:0] DEC_STEPS = 6'd13;   // one 4-bit digit per cycle

    logic [bwe_pkg::W_DIVD-1:0] r_q,   n_q;
    logic [bwe_pkg::W_DATA-1:0] r_rem, n_rem;
    logic [bwe_pkg::W_DATA-1:0] r_dvs;
    logic [W_CNT-1:0]           r_cnt, n_cnt;
    logic                       r_dec;

    logic [bwe_pkg::W_DATA:0]   trial;
    logic                       ge;
    logic [7:0]                 dv;
    logic [15:0]                dprod;
    logic [3:0]                 dq;
    logic [7:0]                 dr;

    always_comb begin
        // restoring step
        trial = {r_rem, r_q[bwe_pkg::W_DIVD-1]};
        ge    = trial >= {1'b0, r_dvs};
        // divide-by-ten digit step: dv < 160, so *205 >> 11 is exact
        dv    = {r_rem[3:0], r_q[bwe_pkg::W_DIVD-1 -: 4]};
        dprod = {8'd0, dv} * 16'd205;
        dq    = dprod[14:11];
        dr    = dv - ({1'b0, dq, 3'b000} + {3'b000, dq, 1'b0});

        n_q   = r_q;
        n_rem = r_rem;
        n_cnt = r_cnt;
        if (i_start) begin
            n_rem = '0;
            if (i_dec) begin
                n_q   = {i_dividend[51:0], 6'd0};
                n_cnt = DEC_STEPS;
            end else begin
                n_q   = i_dividend;
                n_cnt = BIN_STEPS;
            end
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - 6'd1;
            if (r_dec) begin
                n_q   = {r_q[bwe_pkg::W_DIVD-5:0], dq};
                n_rem = {44'd0, dr[3:0]};
            end else begin
                n_q   = {r_q[bwe_pkg::W_DIVD-2:0], ge};
                n_rem = ge ? (trial[bwe_pkg::W_DATA-1:0] - r_dvs)
                           : trial[bwe_pkg::W_DATA-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q   <= n_q;
        r_rem <= n_rem;
        if (i_start) begin
            r_dvs <= i_divisor;
            r_dec <= i_dec;
        end
    end

    assign o_busy = r_cnt != '0;
    assign o_quot = r_q;

endmodule

// ===== hdl/bwe_dp.sv =====
module bwe_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bwe_pkg::t_uop                  i_uop,
    output bwe_pkg::t_flags                o_flags,
    input  logic                           i_cfg_we,
    input  logic [bwe_pkg::W_IDX-1:0]      i_cfg_idx,
    input  logic [bwe_pkg::W_DATA-1:0]     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [bwe_pkg::W_DATA-1:0]     i_now_ms,
    input  logic [bwe_pkg::W_DATA-1:0]     i_bytes_total,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [bwe_pkg::W_DATA-1:0]     o_bw_estimate,
    output logic [bwe_pkg::W_MS-1:0]       o_remaining_ms
);

    function automatic logic [bwe_pkg::W_DIVD-1:0] mul1000(
        input logic [bwe_pkg::W_DATA-1:0] x);
        logic [bwe_pkg::W_DIVD-1:0] xe;
        xe = {10'd0, x};
        return (xe << 10) - (xe << 4) - (xe << 3);
    endfunction

    // config
    logic [bwe_pkg::W_CHUNK-1:0] r_min_chunk;
    logic [bwe_pkg::W_DATA-1:0]  r_range_begin, r_range_end;
    // estimator state
    logic [bwe_pkg::W_DATA-1:0]  r_base_time, r_base_bytes, r_bw;
    // working registers
    logic [bwe_pkg::W_DATA-1:0]  r_now, r_total, r_elapsed, r_gained, r_rate, r_left;
    logic [bwe_pkg::W_MS-1:0]    r_ms;
    // output stage
    logic                        r_out_valid;
    logic [bwe_pkg::W_DATA-1:0]  r_out_bw;
    logic [bwe_pkg::W_MS-1:0]    r_out_ms;

    logic                        accept;
    logic                        out_full;
    logic                        div_start, div_dec, div_busy;
    logic [bwe_pkg::W_DIVD-1:0]  div_dividend, div_quot;
    logic [bwe_pkg::W_DATA-1:0]  div_divisor;
    logic [51:0]                 blend_sum;
    logic [bwe_pkg::W_DATA:0]    used;
    logic [bwe_pkg::W_DATA:0]    end_x;
    logic [bwe_pkg::W_DATA:0]    left_x;

    assign accept     = (i_uop.op == bwe_pkg::OP_ACCEPT) && i_in_valid;
    assign o_in_stall = i_uop.op != bwe_pkg::OP_ACCEPT;
    assign out_full   = r_out_valid && i_out_stall;

    always_comb begin
        // 7*bw + 3*rate, below 10 * 2^48
        blend_sum = ({4'd0, r_bw} << 3) - {4'd0, r_bw}
                  + ({4'd0, r_rate} << 1) + {4'd0, r_rate};
        used      = {1'b0, r_range_begin} + {1'b0, r_total};
        end_x     = {1'b0, r_range_end};
        left_x    = (end_x > used) ? (end_x - used) : '0;

        div_start    = 1'b0;
        div_dec      = 1'b0;
        div_dividend = mul1000(r_gained);
        div_divisor  = r_elapsed;
        unique case (i_uop.op)
            bwe_pkg::OP_RATE_GO: begin
                div_start = 1'b1;
            end
            bwe_pkg::OP_BLEND_GO: begin
                div_start    = 1'b1;
                div_dec      = 1'b1;
                div_dividend = {6'd0, blend_sum};
            end
            bwe_pkg::OP_REM_GO: begin
                div_start    = 1'b1;
                div_dividend = mul1000(r_left);
                div_divisor  = r_bw;
            end
            default: begin
            end
        endcase
    end

    bwe_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dec      (div_dec),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_quot     (div_quot)
    );

    always_comb begin
        o_flags.no_req    = !i_in_valid;
        o_flags.base_zero = r_base_time == '0;
        o_flags.skip      = (r_elapsed == '0) || (r_gained < {32'd0, r_min_chunk});
        o_flags.div_busy  = div_busy;
        o_flags.bw_zero   = r_bw == '0;
        o_flags.out_full  = out_full;
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_chunk   <= bwe_pkg::MIN_CHUNK_RST;
            r_range_begin <= '0;
            r_range_end   <= '0;
            r_base_time   <= '0;
            r_base_bytes  <= '0;
            r_bw          <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    bwe_pkg::REG_MIN_CHUNK:   r_min_chunk   <= i_cfg_data[bwe_pkg::W_CHUNK-1:0];
                    bwe_pkg::REG_RANGE_BEGIN: r_range_begin <= i_cfg_data;
                    bwe_pkg::REG_RANGE_END:   r_range_end   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            unique case (i_uop.op)
                bwe_pkg::OP_BLEND_DONE: begin
                    r_bw         <= div_quot[bwe_pkg::W_DATA-1:0];
                    r_base_time  <= r_now;
                    r_base_bytes <= r_total;
                end
                bwe_pkg::OP_SEED: begin
                    r_bw <= r_rate;
                end
                bwe_pkg::OP_SETBASE: begin
                    r_base_time  <= r_now;
                    r_base_bytes <= r_total;
                end
                default: begin
                end
            endcase
            if ((i_uop.op == bwe_pkg::OP_EMIT) && !out_full) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_now   <= i_now_ms;
            r_total <= i_bytes_total;
        end
        unique case (i_uop.op)
            bwe_pkg::OP_DIFF: begin
                r_elapsed <= r_now - r_base_time;
                r_gained  <= r_total - r_base_bytes;
            end
            bwe_pkg::OP_RATE_SAT: begin
                r_rate <= (div_quot[bwe_pkg::W_DIVD-1:bwe_pkg::W_DATA] != '0)
                        ? '1 : div_quot[bwe_pkg::W_DATA-1:0];
            end
            bwe_pkg::OP_LEFT: begin
                r_left <= left_x[bwe_pkg::W_DATA-1:0];
            end
            bwe_pkg::OP_REM_DONE: begin
                r_ms <= (div_quot[bwe_pkg::W_DIVD-1:bwe_pkg::W_MS] != '0)
                      ? '1 : div_quot[bwe_pkg::W_MS-1:0];
            end
            bwe_pkg::OP_UNKNOWN: begin
                r_ms <= '1;
            end
            bwe_pkg::OP_EMIT: begin
                if (!out_full) begin
                    r_out_bw <= r_bw;
                    r_out_ms <= r_ms;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid    = r_out_valid;
    assign o_bw_estimate  = r_out_bw;
    assign o_remaining_ms = r_out_ms;

endmodule

// ===== hdl/bwe_seq.sv =====
module bwe_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bwe_pkg::t_flags i_flags,
    output bwe_pkg::t_uop   o_uop
);

    logic [bwe_pkg::W_PC-1:0] r_pc, n_pc;
    bwe_pkg::t_uop            uop;
    logic                     take;

    always_comb begin
        uop = bwe_pkg::prog_word(r_pc);
        unique case (uop.cond)
            bwe_pkg::C_NEVER:     take = 1'b0;
            bwe_pkg::C_ALWAYS:    take = 1'b1;
            bwe_pkg::C_NO_REQ:    take = i_flags.no_req;
            bwe_pkg::C_BASE_ZERO: take = i_flags.base_zero;
            bwe_pkg::C_SKIP:      take = i_flags.skip;
            bwe_pkg::C_DIV_BUSY:  take = i_flags.div_busy;
            bwe_pkg::C_BW_ZERO:   take = i_flags.bw_zero;
            bwe_pkg::C_OUT_FULL:  take = i_flags.out_full;
        endcase
        n_pc = take ? uop.target : r_pc + 5'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= bwe_pkg::PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_uop = uop;

endmodule

// ===== hdl/bwe_chk.sv =====
`include "bandwidth_ewma_estimator_macros.svh"

module bwe_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [bwe_pkg::W_DATA-1:0]  o_bw_estimate,
    input logic [bwe_pkg::W_MS-1:0]    o_remaining_ms
);

    logic [bwe_pkg::W_DATA+bwe_pkg::W_MS-1:0] out_payload;

    assign out_payload = {o_bw_estimate, o_remaining_ms};

    // a stalled result stays up and holds its payload
    `BWE_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid)
    `BWE_ASSERT_NEXT(a_out_stable, o_out_valid && i_out_stall, $stable(out_payload))
    // no estimate yet means unknown remaining time
    `BWE_ASSERT_NOW(a_unknown_ms, o_out_valid && (o_bw_estimate == '0), o_remaining_ms == '1)
    // one request in flight: the input closes right after an accept
    `BWE_ASSERT_NEXT(a_one_in_flight, i_in_valid && !o_in_stall, o_in_stall)

endmodule

bind bandwidth_ewma_estimator bwe_chk u_bwe_chk (.*);

// ===== tb/testbench.sv =====
import bwe_pkg::*;

module testbench;

    localparam logic [W_DATA-1:0] MASK48      = {W_DATA{1'b1}};
    localparam logic [W_MS-1:0]   MS_ALL_ONES = {W_MS{1'b1}};
    localparam logic [W_IDX-1:0]  REG_UNUSED  = 2'd3;     // no register behind it
    localparam int                HOLD_CYCLES = 2000;     // long receiver hold-off
    localparam int                DRAIN_CYCLES = 300;     // wait after the last drain for stray results

    // ------------------------------------------------------------------
    // Expected-result store plus a predictor of the estimator state.
    // Every accepted request yields exactly one estimate.
    // ------------------------------------------------------------------
    class estimate_scoreboard;
        logic [W_CHUNK-1:0] min_chunk;
        logic [W_DATA-1:0]  range_begin;
        logic [W_DATA-1:0]  range_end;
        logic [W_DATA-1:0]  base_time;
        logic [W_DATA-1:0]  base_bytes;
        logic [W_DATA-1:0]  bw_value;
        logic [W_DATA-1:0]  exp_bw[$];
        logic [W_MS-1:0]    exp_remaining[$];
        int errors, requests, base_loads, drops, seeds, blends;
        int rate_sats, time_sats, clamps, unknowns;

        function new();
            min_chunk   = MIN_CHUNK_RST;
            range_begin = '0;
            range_end   = '0;
            base_time   = '0;
            base_bytes  = '0;
            bw_value    = '0;
        endfunction

        function void write_reg(logic [W_IDX-1:0] idx, logic [W_DATA-1:0] data);
            case (idx)
                REG_MIN_CHUNK:   min_chunk   = data[W_CHUNK-1:0];
                REG_RANGE_BEGIN: range_begin = data;
                REG_RANGE_END:   range_end   = data;
                default: ;
            endcase
        endfunction

        function bit idle();
            return exp_bw.size() == 0;
        endfunction

        // Advance the predicted state by one receive event, queue the estimate.
        function void note_event(logic [W_DATA-1:0] now, logic [W_DATA-1:0] total);
            logic [63:0] elapsed, gained, rate, mix, used, left, ms;
            requests++;
            if (base_time == '0) begin
                base_time  = now;
                base_bytes = total;
                base_loads++;
            end else begin
                // both deltas wrap at 48 bits
                elapsed = {16'd0, now - base_time};
                gained  = {16'd0, total - base_bytes};
                if (elapsed == 0 || gained < {48'd0, min_chunk}) begin
                    drops++;
                end else begin
                    rate = gained * 64'd1000 / elapsed;
                    if (rate > {16'd0, MASK48}) begin
                        rate = {16'd0, MASK48};
                        rate_sats++;
                    end
                    if (bw_value == '0) begin
                        // seed only; base stays put
                        bw_value = rate[W_DATA-1:0];
                        seeds++;
                    end else begin
                        mix        = 64'd7 * {16'd0, bw_value} + 64'd3 * rate;
                        mix        = mix / 64'd10;
                        bw_value   = mix[W_DATA-1:0];
                        base_time  = now;
                        base_bytes = total;
                        blends++;
                    end
                end
            end

            if (bw_value == '0) begin
                ms = {32'd0, MS_ALL_ONES};
                unknowns++;
            end else begin
                used = {16'd0, range_begin} + {16'd0, total};
                left = ({16'd0, range_end} > used) ? {16'd0, range_end} - used : 64'd0;
                if (left == 0)
                    clamps++;
                ms = left * 64'd1000 / {16'd0, bw_value};
                if (ms > {32'd0, MS_ALL_ONES}) begin
                    ms = {32'd0, MS_ALL_ONES};
                    time_sats++;
                end
            end
            exp_bw.push_back(bw_value);
            exp_remaining.push_back(ms[W_MS-1:0]);
        endfunction

        function void check_result(logic [W_DATA-1:0] bw, logic [W_MS-1:0] ms);
            logic [W_DATA-1:0] want_bw;
            logic [W_MS-1:0]   want_ms;
            if (exp_bw.size() == 0) begin
                errors++;
                $display("%0t: estimate with no request pending: bw %0d remaining %0d",
                         $time, bw, ms);
                return;
            end
            want_bw = exp_bw.pop_front();
            want_ms = exp_remaining.pop_front();
            if (bw !== want_bw) begin
                errors++;
                $display("%0t: bw_estimate mismatch: expected %0d actual %0d",
                         $time, want_bw, bw);
            end
            if (ms !== want_ms) begin
                errors++;
                $display("%0t: remaining_ms mismatch: expected %0d actual %0d",
                         $time, want_ms, ms);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT hookup; all inputs known from time zero
    // ------------------------------------------------------------------
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [W_IDX-1:0]   i_cfg_idx = '0;
    logic [W_DATA-1:0]  i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [W_DATA-1:0]  i_now_ms = '0;
    logic [W_DATA-1:0]  i_bytes_total = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [W_DATA-1:0]  o_bw_estimate;
    logic [W_MS-1:0]    o_remaining_ms;

    bandwidth_ewma_estimator i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_now_ms       (i_now_ms),
        .i_bytes_total  (i_bytes_total),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_bw_estimate  (o_bw_estimate),
        .o_remaining_ms (o_remaining_ms)
    );

    estimate_scoreboard sb = new();

    int send_idle_pct = 27;
    int recv_idle_pct = 76;
    int hold_token = 0;       // bumped by the stimulus to request a long hold-off
    int hold_seen = 0;
    int hold_left = 0;

    // generator position for well-formed event streams
    logic [W_DATA-1:0] cur_time;
    logic [W_DATA-1:0] cur_bytes;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Receiver: random stall, or a counted hold-off when one is requested.
    always @(negedge i_clk) begin
        if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Both handshakes are sampled here; pre-edge values only.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                sb.check_result(o_bw_estimate, o_remaining_ms);
            if (i_in_valid && !o_in_stall)
                sb.note_event(i_now_ms, i_bytes_total);
        end
    end

    function automatic logic [W_DATA-1:0] rand48();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[W_DATA-1:0];
    endfunction

    // Offer one request; returns on the falling edge after it is taken.
    // Valid is left high so back-to-back requests need no extra step.
    task automatic send_event(input logic [W_DATA-1:0] now, input logic [W_DATA-1:0] total);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_now_ms      <= now;
        i_bytes_total <= total;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    // Stop offering and wait until every outstanding estimate is back.
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (!sb.idle());
    endtask

    // Only called with the block idle. The unused index goes first, it must not stick.
    task automatic set_regs(input logic [W_CHUNK-1:0] mc, input logic [W_DATA-1:0] rb,
                            input logic [W_DATA-1:0] re);
        logic [W_IDX-1:0]  idx[4];
        logic [W_DATA-1:0] val[4];
        idx = '{REG_UNUSED, REG_MIN_CHUNK, REG_RANGE_BEGIN, REG_RANGE_END};
        val = '{MASK48, {32'd0, mc}, rb, re};
        for (int k = 0; k < 4; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx[k];
            i_cfg_data <= val[k];
            sb.write_reg(idx[k], val[k]);
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Mostly well-formed streams (time and count moving forward around
    // min_chunk), with some noise: random points, stopped clock, backward steps.
    task automatic random_event(output logic [W_DATA-1:0] now,
                                output logic [W_DATA-1:0] total);
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 6) begin
            now   = rand48();
            total = rand48();
        end else if (pick < 9) begin
            now   = '0;
            total = cur_bytes + $urandom_range(5000);
        end else if (pick < 12) begin
            now   = cur_time - $urandom_range(1, 50);
            total = cur_bytes - $urandom_range(1, 3000);
        end else begin
            if (pick >= 16)
                cur_time = cur_time + $urandom_range(1, 400);
            if (pick < 22 && sb.min_chunk != 0)
                cur_bytes = cur_bytes + $urandom_range(0, sb.min_chunk - 1);
            else
                cur_bytes = cur_bytes + sb.min_chunk + $urandom_range(0, 6000);
            now   = cur_time;
            total = cur_bytes;
        end
    endtask

    initial begin
        logic [W_DATA-1:0] now, total;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // --- directed, register defaults ---
        send_event(48'd0, 48'd5);         // clock not started: base stays zero
        send_event(48'd10, 48'd50);       // base load
        send_event(48'd10, 48'd5000);     // no time elapsed: dropped
        send_event(48'd15, 48'd1073);     // 1023 new bytes, below default chunk
        drain();

        set_regs(16'd0, 48'd100, MASK48);
        send_event(48'd20, 48'd50);       // zero rate, estimate stays unknown
        send_event(48'd30, 48'd60);       // seeds the estimate
        send_event(48'd40, 48'd1060);     // first blend, remaining time saturates
        send_event(48'd41, MASK48);       // rate saturates, range already covered
        send_event(48'd40, 48'd2000);     // time and count run backward
        send_event(48'd0, 48'd5000);      // blend moves base time to zero
        send_event(48'd100, 48'd9000);    // so this reloads the base
        drain();

        set_regs(16'hFFFF, 48'd0, 48'd1000000);
        send_event(48'd200, 48'd74534);   // one byte short of min_chunk
        send_event(48'd300, 48'd74535);   // exactly min_chunk
        send_event(48'd400, 48'd144535);
        send_event(MASK48, 48'd250000);
        send_event(48'd7, 48'd900000);
        drain();

        // --- random phases: idling pattern and registers vary per phase ---
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_regs(MIN_CHUNK_RST, 48'd0, 48'd1 << 36);
                1: set_regs(W_CHUNK'($urandom), rand48(), rand48());
                2: set_regs(16'd0, 48'd0, MASK48);
                3: set_regs(16'hFFFF, 48'($urandom_range(1000)), 48'd1 << 30);
                4: set_regs(W_CHUNK'($urandom_range(1, 4096)), 48'd0, rand48());
                default: set_regs(16'd512, MASK48, MASK48);
            endcase
            send_idle_pct = (ph < 2) ? 27 : (ph < 4) ? 76 : 0;
            recv_idle_pct = (ph < 2) ? 76 : (ph < 4) ? 27 : 0;
            cur_time  = ph[0] ? rand48() : W_DATA'($urandom_range(1, 1000));
            cur_bytes = ph[0] ? rand48() : '0;
            for (int n = 0; n < 90; n++) begin
                if (n == 45)
                    drain();              // sender pauses until all estimates are in
                if (ph == 4 && n == 0)
                    hold_token <= hold_token + 1;   // fills the block, input stalls
                random_event(now, total);
                send_event(now, total);
            end
            drain();
        end

        // stray results after the last one would still be flagged here
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests: %0d base loads, %0d dropped, %0d seeds, %0d blends",
                 sb.requests, sb.base_loads, sb.drops, sb.seeds, sb.blends);
        $display("Saturated rates %0d, saturated times %0d, covered ranges %0d, unknown %0d",
                 sb.rate_sats, sb.time_sats, sb.clamps, sb.unknowns);
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // hang guard, far above the slowest legal run
    initial begin
        #12000000;
        $display("Timeout waiting for the estimator");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/bwe_pkg.sv
hdl/bwe_div.sv
hdl/bwe_dp.sv
hdl/bwe_seq.sv
hdl/bandwidth_ewma_estimator.sv
hdl/bwe_chk.sv
tb/testbench.sv
